// ===== rtl/core/npn_truth_table_matcher_defines.svh =====
// assertion macros shared by the npn matcher rtl
// used by npn_truth_table_matcher, needs clk and arst_n in scope
`ifndef NPN_TRUTH_TABLE_MATCHER_DEFINES_SVH
`define NPN_TRUTH_TABLE_MATCHER_DEFINES_SVH
// same-cycle implication
`define NTM_AST_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("npn matcher check failed");
// next-cycle implication
`define NTM_AST_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("npn matcher check failed");
`endif

// ===== rtl/core/ntm_pkg.sv =====
// constants, codes and truth table helpers for the npn matcher
// no dependencies
`timescale 1ns / 1ps
package ntm_pkg;
	localparam int LIB_DEPTH = 256;
	localparam int MAX_VARS = 4;
	localparam int ADDR_W = $clog2(LIB_DEPTH);
	localparam int CNT_W = $clog2(LIB_DEPTH + 1);
	localparam int NUM_PERMS = 24;
	localparam int NUM_VARIANTS = NUM_PERMS + MAX_VARS;
	localparam int GEN_W = $clog2(NUM_VARIANTS);

	localparam logic [1:0] OP_LOAD = 2'd0;
	localparam logic [1:0] OP_QUERY = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_MATCH = 2'd2;
	localparam logic [1:0] ST_NOMATCH = 2'd3;

	// p[v] in bits [2v+1:2v], all orderings of four variables
	localparam logic [7:0] PERMS [NUM_PERMS] = '{
		8'hE4, 8'hB4, 8'hD8, 8'h78, 8'h9C, 8'h6C,
		8'hE1, 8'hB1, 8'hC9, 8'h39, 8'h8D, 8'h2D,
		8'hD2, 8'h72, 8'hC6, 8'h36, 8'h4E, 8'h1E,
		8'h93, 8'h63, 8'h87, 8'h27, 8'h4B, 8'h1B
	};

	function automatic logic [2:0] eff_vars(input logic [2:0] raw);
		logic [2:0] n;
		n = raw;
		if (n < 3'd1) n = 3'd1;
		if (n > 3'(MAX_VARS)) n = 3'(MAX_VARS);
		return n;
	endfunction

	function automatic logic [15:0] table_mask(input logic [2:0] n);
		logic [15:0] m;
		m = '0;
		for (int b = 0; b < 16; b++) begin
			if (b < (1 << n)) m[b] = 1'b1;
		end
		return m;
	endfunction

	// true when the first n entries of the ordering are all below n
	function automatic logic perm_ok(input logic [7:0] p, input logic [2:0] n);
		logic ok;
		ok = 1'b1;
		for (int v = 0; v < 4; v++) begin
			if (v < n && {1'b0, p[2*v +: 2]} >= n) ok = 1'b0;
		end
		return ok;
	endfunction

	function automatic logic [15:0] permute(input logic [15:0] t, input logic [2:0] n,
			input logic [7:0] p);
		logic [15:0] r;
		logic [3:0] src;
		logic [3:0] iv;
		int pos;
		r = '0;
		for (int i = 0; i < 16; i++) begin
			iv = 4'(i);
			src = '0;
			for (int v = 0; v < 4; v++) begin
				if (v < n) begin
					pos = (int'(n) - 1 - int'(p[2*v +: 2])) & 3;
					src[(int'(n) - 1 - v) & 3] = iv[pos];
				end
			end
			if (i < (1 << n)) r[i] = t[src];
		end
		return r;
	endfunction

	// negate the first k variables (the high index bits)
	function automatic logic [15:0] negate(input logic [15:0] t, input logic [2:0] n,
			input logic [2:0] k);
		logic [15:0] r;
		logic [3:0] xm;
		logic [3:0] iv;
		r = '0;
		xm = 4'(((1 << k) - 1) << (int'(n) - int'(k)));
		for (int i = 0; i < 16; i++) begin
			iv = 4'(i);
			if (i < (1 << n)) r[i] = t[iv ^ xm];
		end
		return r;
	endfunction

	// minterm 0 becomes the msb
	function automatic logic [15:0] order_key(input logic [15:0] t);
		logic [15:0] key;
		for (int b = 0; b < 16; b++) key[15 - b] = t[b];
		return key;
	endfunction
endpackage

// ===== rtl/core/npn_truth_table_matcher.sv =====
// npn equivalence matcher for truth tables of up to four inputs
// uses ntm_pkg, ntm_ram and npn_truth_table_matcher_defines.svh
//
// channel   dir  handshake          payload
// s_axis    in   s_tvalid/s_tready  tdata: table_bits, tuser: op
// m_axis    out  m_tvalid/m_tready  tdata: entry_index,neg_inputs,neg_output; tuser: status
// cfg       in   cfg_valid/cfg_ready  cfg_data: num_vars
//
// load, clear and unused ops are done without leaving IDLE; a query first builds
// its variants, then reads one loaded entry per cycle through the library ram
// port, then drains the read and posts the item.
// reset empties the library at once (fill count), no clearing pass.
// input is taken only between queries and while the output register is free.
`timescale 1ns / 1ps
`include "npn_truth_table_matcher_defines.svh"
module npn_truth_table_matcher (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // [15:0] table_bits
	input  logic [1:0]  s_tuser,  // [1:0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [7:0] entry_index, [10:8] neg_inputs, [11] neg_output
	output logic [1:0]  m_tuser,  // [1:0] status
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);
	typedef enum logic [2:0] {IDLE, GEN, SCAN, DRAIN, DONE} state_t;

	state_t state_q;
	logic [2:0] nvars_q;
	logic [ntm_pkg::CNT_W-1:0] count_q;
	logic [ntm_pkg::CNT_W-1:0] scan_q;
	logic [ntm_pkg::GEN_W-1:0] gen_q;
	logic [15:0] qtab_q;
	logic [2:0] n_q;
	logic [15:0] mask_q;
	logic [15:0] var_q [ntm_pkg::NUM_VARIANTS];
	logic [ntm_pkg::NUM_VARIANTS-1:0] var_v_q;
	logic rd_v_s1;
	logic [ntm_pkg::ADDR_W-1:0] rd_idx_s1;
	logic found_q;
	logic [15:0] best_key_q;
	logic [7:0] best_idx_q;
	logic [2:0] best_k_q;
	logic best_o_q;
	logic m_tvalid_q;
	logic [15:0] m_tdata_q;
	logic [1:0] m_tuser_q;

	logic accept;
	logic ram_we;
	logic [ntm_pkg::ADDR_W-1:0] ram_addr;
	logic [15:0] ram_rdata;
	logic [15:0] lt;
	logic [15:0] lt_key;
	logic [9:0] hits;
	logic hit;
	logic [3:0] hit_code;
	logic [15:0] gen_tab;
	logic gen_ok;
	logic [2:0] gen_k;
	logic [2:0] n_eff;

	assign cfg_ready = 1'b1;
	assign s_tready = (state_q == IDLE) && (!m_tvalid_q || m_tready);
	assign accept = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tuser = m_tuser_q;
	assign n_eff = ntm_pkg::eff_vars(nvars_q);

	assign ram_we = accept && (s_tuser == ntm_pkg::OP_LOAD)
		&& (count_q < ntm_pkg::CNT_W'(ntm_pkg::LIB_DEPTH));
	assign ram_addr = (state_q == SCAN) ? scan_q[ntm_pkg::ADDR_W-1:0]
		: count_q[ntm_pkg::ADDR_W-1:0];

	ntm_ram #(.WIDTH(16), .DEPTH(ntm_pkg::LIB_DEPTH)) u_lib (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (s_tdata),
		.rdata (ram_rdata)
	);

	// one variant per cycle: permutations first, then leading negations
	always_comb begin
		gen_k = '0;
		if (gen_q < ntm_pkg::GEN_W'(ntm_pkg::NUM_PERMS)) begin
			gen_tab = ntm_pkg::permute(qtab_q, n_q, ntm_pkg::PERMS[gen_q]);
			gen_ok = ntm_pkg::perm_ok(ntm_pkg::PERMS[gen_q], n_q);
		end else begin
			gen_k = 3'(gen_q - ntm_pkg::GEN_W'(ntm_pkg::NUM_PERMS - 1));
			gen_tab = ntm_pkg::negate(qtab_q, n_q, gen_k);
			gen_ok = (n_q > 3'd1) && (gen_k <= n_q);
		end
	end

	// hits[2k+o]: a variant with k negated inputs and output flag o matches
	always_comb begin
		lt = ram_rdata & mask_q;
		lt_key = ntm_pkg::order_key(lt);
		hits = '0;
		for (int j = 0; j < ntm_pkg::NUM_VARIANTS; j++) begin
			if (var_v_q[j]) begin
				if (j < ntm_pkg::NUM_PERMS) begin
					if (var_q[j] == lt) hits[0] = 1'b1;
					if ((~var_q[j] & mask_q) == lt) hits[1] = 1'b1;
				end else begin
					if (var_q[j] == lt) hits[2 * (j - ntm_pkg::NUM_PERMS + 1)] = 1'b1;
					if ((~var_q[j] & mask_q) == lt)
						hits[2 * (j - ntm_pkg::NUM_PERMS + 1) + 1] = 1'b1;
				end
			end
		end
		hit = |hits;
		hit_code = '0;
		for (int c = 9; c >= 0; c--) begin
			if (hits[c]) hit_code = 4'(c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			nvars_q <= 3'd4;
			count_q <= '0;
			scan_q <= '0;
			gen_q <= '0;
			var_v_q <= '0;
			rd_v_s1 <= 1'b0;
			found_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cfg_valid) nvars_q <= cfg_data;
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			rd_v_s1 <= 1'b0;
			rd_idx_s1 <= scan_q[ntm_pkg::ADDR_W-1:0];
			if (rd_v_s1 && hit && (!found_q || lt_key < best_key_q)) begin
				found_q <= 1'b1;
				best_key_q <= lt_key;
				best_idx_q <= 8'(rd_idx_s1);
				best_k_q <= 3'(hit_code[3:1]);
				best_o_q <= hit_code[0];
			end
			case (state_q)
				IDLE: begin
					if (accept) begin
						m_tdata_q <= '0;
						case (s_tuser)
							ntm_pkg::OP_LOAD: begin
								m_tvalid_q <= 1'b1;
								if (ram_we) begin
									count_q <= count_q + 1'b1;
									m_tuser_q <= ntm_pkg::ST_DONE;
								end else begin
									m_tuser_q <= ntm_pkg::ST_FULL;
								end
							end
							ntm_pkg::OP_CLEAR: begin
								m_tvalid_q <= 1'b1;
								m_tuser_q <= ntm_pkg::ST_DONE;
								count_q <= '0;
							end
							ntm_pkg::OP_QUERY: begin
								n_q <= n_eff;
								mask_q <= ntm_pkg::table_mask(n_eff);
								qtab_q <= s_tdata & ntm_pkg::table_mask(n_eff);
								gen_q <= '0;
								var_v_q <= '0;
								found_q <= 1'b0;
								state_q <= GEN;
							end
							default: ;
						endcase
					end
				end
				GEN: begin
					var_q[gen_q] <= gen_tab;
					var_v_q[gen_q] <= gen_ok;
					gen_q <= gen_q + 1'b1;
					scan_q <= '0;
					if (gen_q == ntm_pkg::GEN_W'(ntm_pkg::NUM_VARIANTS - 1)) begin
						state_q <= (count_q == '0) ? DONE : SCAN;
					end
				end
				SCAN: begin
					rd_v_s1 <= 1'b1;
					scan_q <= scan_q + 1'b1;
					if (scan_q == count_q - 1'b1) state_q <= DRAIN;
				end
				DRAIN: state_q <= DONE;
				DONE: begin
					m_tvalid_q <= 1'b1;
					if (found_q) begin
						m_tuser_q <= ntm_pkg::ST_MATCH;
						m_tdata_q <= {4'd0, best_o_q, best_k_q, best_idx_q};
					end else begin
						m_tuser_q <= ntm_pkg::ST_NOMATCH;
						m_tdata_q <= '0;
					end
					state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	`NTM_AST_NOW(a_count_bound, 1'b1, count_q <= ntm_pkg::CNT_W'(ntm_pkg::LIB_DEPTH))
	`NTM_AST_NOW(a_no_write_in_query, ram_we, state_q == IDLE)
	`NTM_AST_NXT(a_match_in_range, state_q == DONE && found_q,
		{1'b0, m_tdata_q[7:0]} < count_q || count_q == ntm_pkg::CNT_W'(ntm_pkg::LIB_DEPTH))
endmodule

// ===== rtl/core/ntm_ram.sv =====
// generic single port ram with registered read
// no dependencies
`timescale 1ns / 1ps
module ntm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem_q[addr] <= wdata;
		rdata <= mem_q[addr];
	end
endmodule

// ===== test/tb_top.sv =====
// self-checking testbench for npn_truth_table_matcher: loads, clears and npn queries
// checked against an in-file behavioral predictor; depends on ntm_pkg and the rtl
`timescale 1ns / 1ps

class npn_result_board;
	logic [1:0]  exp_status [$];
	logic [15:0] exp_data [$];
	int errors;

	function new();
		errors = 0;
	endfunction

	function void note_item(logic [1:0] st, logic [7:0] idx, logic [2:0] k, logic o);
		exp_status.push_back(st);
		exp_data.push_back({4'd0, o, k, idx});
	endfunction

	function void check_result(logic [1:0] st, logic [15:0] d);
		logic [1:0]  es;
		logic [15:0] ed;
		if (exp_status.size() == 0) begin
			$display("%0t: unexpected result status %0d data %h", $time, st, d);
			errors++;
			return;
		end
		es = exp_status.pop_front();
		ed = exp_data.pop_front();
		if (st !== es) begin
			$display("%0t: status expected %0d actual %0d", $time, es, st);
			errors++;
		end
		if (d[7:0] !== ed[7:0]) begin
			$display("%0t: entry_index expected %0d actual %0d", $time, ed[7:0], d[7:0]);
			errors++;
		end
		if (d[10:8] !== ed[10:8]) begin
			$display("%0t: neg_inputs expected %0d actual %0d", $time, ed[10:8], d[10:8]);
			errors++;
		end
		if (d[11] !== ed[11]) begin
			$display("%0t: neg_output expected %0d actual %0d", $time, ed[11], d[11]);
			errors++;
		end
	endfunction
endclass

module tb_top;
	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [15:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [2:0]  cfg_data;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	npn_result_board board;
	logic [15:0] lib_tables [ntm_pkg::LIB_DEPTH];
	int          lib_count;
	logic [2:0]  vars_reg;
	int          send_idle;
	int          recv_idle;

	npn_truth_table_matcher dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#200ms;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// bit i of the result takes bit src(i) of t, p[v] picks the variable at position v
	function automatic logic [15:0] perm_table(logic [15:0] t, int n, int p [4]);
		logic [15:0] r;
		int src;
		r = '0;
		for (int i = 0; i < (1 << n); i++) begin
			src = 0;
			for (int v = 0; v < n; v++)
				src |= ((i >> (n - 1 - p[v])) & 1) << (n - 1 - v);
			r[i] = t[src];
		end
		return r;
	endfunction

	function automatic logic [15:0] minterm_rev(logic [15:0] t, int n);
		logic [15:0] key;
		key = '0;
		for (int b = 0; b < (1 << n); b++) key = {key[14:0], t[b]};
		return key;
	endfunction

	// npn search over the current library
	function automatic void predict_query(logic [15:0] q, output logic [1:0] st,
			output logic [7:0] idx, output logic [2:0] bk_out, output logic bo_out);
		logic [15:0] vt [64];
		int vk [64];
		int vo [64];
		int nv, n, base, xm, bk, bo;
		int p [4];
		logic [15:0] mask, lt, r, key, best_key;
		logic found, hit, ok;
		n = (vars_reg < 1) ? 1 : (vars_reg > ntm_pkg::MAX_VARS) ? ntm_pkg::MAX_VARS : vars_reg;
		mask = (n == 4) ? 16'hFFFF : 16'((1 << (1 << n)) - 1);
		q &= mask;
		nv = 0;
		for (int c = 0; c < (1 << (2 * n)); c++) begin
			ok = 1'b1;
			for (int v = 0; v < 4; v++) p[v] = 0;
			for (int v = 0; v < n; v++) begin
				p[v] = (c >> (2 * v)) & 3;
				if (p[v] >= n) ok = 1'b0;
				for (int u = 0; u < v; u++) if (p[u] == p[v]) ok = 1'b0;
			end
			if (ok) begin
				vt[nv] = perm_table(q, n, p);
				vk[nv] = 0;
				vo[nv] = 0;
				nv++;
			end
		end
		if (n > 1) begin
			for (int k = 1; k <= n; k++) begin
				xm = ((1 << k) - 1) << (n - k);
				r = '0;
				for (int i = 0; i < (1 << n); i++) r[i] = q[(i ^ xm) & 15];
				vt[nv] = r;
				vk[nv] = k;
				vo[nv] = 0;
				nv++;
			end
		end
		base = nv;
		for (int i = 0; i < base; i++) begin
			vt[nv] = ~vt[i] & mask;
			vk[nv] = vk[i];
			vo[nv] = 1;
			nv++;
		end
		found = 1'b0;
		best_key = '0;
		st = ntm_pkg::ST_NOMATCH;
		idx = '0;
		bk_out = '0;
		bo_out = 1'b0;
		for (int e = 0; e < lib_count; e++) begin
			lt = lib_tables[e] & mask;
			hit = 1'b0;
			bk = 0;
			bo = 0;
			for (int j = 0; j < nv; j++) begin
				if (vt[j] == lt) begin
					if (!hit || vk[j] < bk || (vk[j] == bk && vo[j] < bo)) begin
						bk = vk[j];
						bo = vo[j];
					end
					hit = 1'b1;
				end
			end
			if (hit) begin
				key = minterm_rev(lt, n);
				if (!found || key < best_key) begin
					found = 1'b1;
					best_key = key;
					st = ntm_pkg::ST_MATCH;
					idx = 8'(e);
					bk_out = 3'(bk);
					bo_out = bo[0];
				end
			end
		end
	endfunction

	function automatic void predict_item(logic [1:0] op, logic [15:0] t);
		logic [1:0] st;
		logic [7:0] idx;
		logic [2:0] k;
		logic o;
		st = ntm_pkg::ST_DONE;
		idx = '0;
		k = '0;
		o = 1'b0;
		case (op)
			ntm_pkg::OP_LOAD: begin
				if (lib_count < ntm_pkg::LIB_DEPTH) begin
					lib_tables[lib_count] = t;
					lib_count++;
				end else begin
					st = ntm_pkg::ST_FULL;
				end
			end
			ntm_pkg::OP_CLEAR: lib_count = 0;
			ntm_pkg::OP_QUERY: predict_query(t, st, idx, k, o);
			default: return;
		endcase
		board.note_item(st, idx, k, o);
	endfunction

	// valid stays up into the next item when there is no gap
	task automatic send_item(logic [1:0] op, logic [15:0] t);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= t;
		do @(posedge clk); while (!s_tready);
		predict_item(op, t);
		@(negedge clk);
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (board.exp_status.size() != 0) @(negedge clk);
		// an unused op yields nothing, give the block its worst latency
		repeat (300) @(negedge clk);
	endtask

	task automatic write_vars(logic [2:0] val);
		cfg_valid <= 1'b1;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		vars_reg = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// random table mostly drawn from the library so queries tend to hit
	function automatic logic [15:0] pick_table();
		if (lib_count > 0 && $urandom_range(2) != 0)
			return lib_tables[$urandom_range(lib_count - 1)];
		return 16'($urandom);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_result(m_tuser, m_tdata);
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle);
	end

	initial begin
		logic [2:0] cfgs [6];
		int r;
		board = new();
		lib_count = 0;
		vars_reg = 3'd4;
		send_idle = 0;
		recv_idle = 0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ntm_pkg::OP_LOAD;
		m_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		// directed: extremes, every op, equal tables, empty library, full library
		send_item(ntm_pkg::OP_QUERY, 16'h1234);
		send_item(ntm_pkg::OP_LOAD, 16'h0000);
		send_item(ntm_pkg::OP_LOAD, 16'hFFFF);
		send_item(ntm_pkg::OP_LOAD, 16'h8000);
		send_item(ntm_pkg::OP_LOAD, 16'h8000);
		send_item(ntm_pkg::OP_LOAD, 16'hA5C3);
		send_item(ntm_pkg::OP_QUERY, 16'hFFFF);
		send_item(ntm_pkg::OP_QUERY, 16'h0001);
		send_item(ntm_pkg::OP_QUERY, 16'h5A3C);
		send_item(ntm_pkg::OP_QUERY, 16'h00FF);
		send_item(OP_UNUSED, 16'h7777);
		send_item(ntm_pkg::OP_CLEAR, 16'hFFFF);
		send_item(ntm_pkg::OP_QUERY, 16'h0000);
		for (int i = 0; i < ntm_pkg::LIB_DEPTH; i++)
			send_item(ntm_pkg::OP_LOAD, 16'($urandom));
		send_item(ntm_pkg::OP_LOAD, 16'hFFFF);
		send_item(ntm_pkg::OP_QUERY, 16'h6996);
		send_item(ntm_pkg::OP_CLEAR, 16'h0000);
		wait_drain();

		cfgs = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd4};
		for (int ph = 0; ph < 6; ph++) begin
			write_vars(cfgs[ph]);
			send_idle = (ph < 2) ? 19 : (ph < 4) ? 77 : 0;
			recv_idle = (ph < 2) ? 77 : (ph < 4) ? 19 : 0;
			for (int i = 0; i < 80; i++) begin
				r = $urandom_range(99);
				if (r < 45) send_item(ntm_pkg::OP_LOAD, 16'($urandom));
				else if (r < 93) send_item(ntm_pkg::OP_QUERY, pick_table());
				else if (r < 97) send_item(ntm_pkg::OP_CLEAR, 16'($urandom));
				else send_item(OP_UNUSED, 16'($urandom));
			end
			wait_drain();
		end

		if (board.errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
